// ===== rtl/core/fem_pkg.sv =====
// Shared types and constants of the element-wise floating-point multiplier.
package fem_pkg;

	typedef enum logic [1:0] {
		KIND_NUM,
		KIND_ZERO,
		KIND_INF,
		KIND_NAN
	} kind_t;

	localparam logic signed [9:0] BIAS32 = 10'sd127;
	localparam logic signed [9:0] BIAS16 = 10'sd15;
	localparam logic signed [9:0] EMAX32 = 10'sd255;
	localparam logic signed [9:0] EMAX16 = 10'sd31;
	localparam logic [9:0] SHIFT_BASE32 = 10'd23;
	localparam logic [9:0] SHIFT_BASE16 = 10'd36;
	localparam logic [9:0] SHIFT_CAP = 10'd50;
	localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
	localparam logic [31:0] QNAN16 = 32'h0000_7E00;
	localparam logic [31:0] INF32 = 32'h7F80_0000;
	localparam logic [31:0] INF16 = 32'h0000_7C00;

	typedef struct packed {
		kind_t kind;
		logic sign;
		logic signed [9:0] ea;
		logic signed [9:0] eb;
		logic [23:0] ma;
		logic [23:0] mb;
	} unpacked_t;

	typedef struct packed {
		logic signed [9:0] be;
		logic [25:0] q;
		logic guard;
		logic sticky;
	} aligned_t;

endpackage

// ===== rtl/core/fem_unpack.sv =====
// Operand decode: field split, classification and subnormal normalization.
module fem_unpack (
	input logic fmt,
	input logic [31:0] factor_a,
	input logic [31:0] factor_b,
	output fem_pkg::unpacked_t op
);

	typedef struct packed {
		logic s;
		logic nan;
		logic inf;
		logic zero;
		logic signed [9:0] e;
		logic [23:0] m;
	} opnd_t;

	// Binary16 significands are left-aligned into the 24-bit field so that
	// one datapath serves both formats.
	function automatic opnd_t dec(input logic f16, input logic [31:0] v);
		opnd_t o;
		logic [7:0] x;
		logic [22:0] f;
		logic [23:0] m;
		logic [4:0] lz;
		logic xmax;
		if (f16) begin
			x = {3'b000, v[14:10]};
			f = {v[9:0], 13'b0};
			o.s = v[15];
			xmax = (v[14:10] == 5'h1F);
		end else begin
			x = v[30:23];
			f = v[22:0];
			o.s = v[31];
			xmax = (v[30:23] == 8'hFF);
		end
		m = {(x != 8'd0), f};
		lz = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (m[i]) begin
				lz = 5'(23 - i);
			end
		end
		o.nan = xmax && (f != 23'd0);
		o.inf = xmax && (f == 23'd0);
		o.zero = (x == 8'd0) && (f == 23'd0);
		o.m = m << lz;
		o.e = $signed({2'b00, (x == 8'd0) ? 8'd1 : x}) - $signed({5'b00000, lz});
		return o;
	endfunction

	opnd_t da;
	opnd_t db;

	always_comb begin
		da = dec(fmt, factor_a);
		db = dec(fmt, factor_b);
		op.sign = da.s ^ db.s;
		op.ea = da.e;
		op.eb = db.e;
		op.ma = da.m;
		op.mb = db.m;
		if (da.nan || db.nan || (da.inf && db.zero) || (db.inf && da.zero)) begin
			op.kind = fem_pkg::KIND_NAN;
		end else if (da.inf || db.inf) begin
			op.kind = fem_pkg::KIND_INF;
		end else if (da.zero || db.zero) begin
			op.kind = fem_pkg::KIND_ZERO;
		end else begin
			op.kind = fem_pkg::KIND_NUM;
		end
	end

endmodule

// ===== rtl/core/fem_align.sv =====
// Product alignment: exponent fix-up, underflow shift, guard and sticky bits.
module fem_align (
	input logic fmt,
	input logic [47:0] prod,
	input logic signed [9:0] esum,
	output fem_pkg::aligned_t al
);

	logic signed [9:0] be;
	logic [9:0] sh;
	logic [5:0] shr;
	logic [63:0] pw;
	logic [63:0] x;
	logic [63:0] mask;

	always_comb begin
		be = esum + $signed({9'd0, prod[47]});
		sh = (fmt ? fem_pkg::SHIFT_BASE16 : fem_pkg::SHIFT_BASE32) + {9'd0, prod[47]};
		if (be < 10'sd1) begin
			sh = sh + 10'(10'sd1 - be);
		end
		if (sh > fem_pkg::SHIFT_CAP) begin
			sh = fem_pkg::SHIFT_CAP;
		end
		shr = 6'(sh - 10'd1);
		pw = {16'd0, prod};
		x = pw >> shr;
		mask = (64'd1 << shr) - 64'd1;
		al.be = be;
		al.q = x[26:1];
		al.guard = x[0];
		al.sticky = |(pw & mask);
	end

endmodule

// ===== rtl/core/fem_round.sv =====
// Rounding to nearest-even, packing, overflow and special-value selection.
module fem_round (
	input logic fmt,
	input logic sign,
	input fem_pkg::kind_t kind,
	input fem_pkg::aligned_t al,
	output logic [31:0] result
);

	logic [25:0] qr;
	logic [33:0] bexp;
	logic [33:0] bits;
	logic ovf;
	logic [31:0] mag;
	logic [31:0] sbit;

	always_comb begin
		qr = al.q + {25'd0, al.guard & (al.sticky | al.q[0])};
		bexp = 34'(unsigned'(al.be - 10'sd1));
		if (al.be >= 10'sd1) begin
			bits = (fmt ? (bexp << 10) : (bexp << 23)) + {8'd0, qr};
		end else begin
			bits = {8'd0, qr};
		end
		ovf = (al.be >= (fmt ? fem_pkg::EMAX16 : fem_pkg::EMAX32))
			|| (bits >= {2'b00, (fmt ? fem_pkg::INF16 : fem_pkg::INF32)});
		sbit = fmt ? {16'd0, sign, 15'd0} : {sign, 31'd0};
		mag = ovf ? (fmt ? fem_pkg::INF16 : fem_pkg::INF32) : bits[31:0];
		unique case (kind)
			fem_pkg::KIND_NAN: result = fmt ? fem_pkg::QNAN16 : fem_pkg::QNAN32;
			fem_pkg::KIND_INF: result = sbit | (fmt ? fem_pkg::INF16 : fem_pkg::INF32);
			fem_pkg::KIND_ZERO: result = sbit;
			default: result = sbit | mag;
		endcase
	end

endmodule

// ===== rtl/core/elementwise_float_multiplier.sv =====
// Top level: four-stage IEEE 754 binary32/binary16 multiplier on a stream interface.
// Items pass the stage 1 to 4 registers in order; throughput is one item per cycle
// unless the master side stalls. The 24x24 significand multiply sets the stage depth.
// Each stage advances when it is empty or the stage after it moves, so bubbles close up.
// Reset (arst_n low) empties every stage and sets number_format to binary32.
// Payload registers are not reset; only the valid bits and the format register are.
module elementwise_float_multiplier (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,               // number_format: 0 binary32, 1 binary16
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata,     // [31:0] factor_a, [63:32] factor_b
	input logic s_axis_tlast,            // last_element
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata,    // [31:0] product_bits
	output logic m_axis_tlast            // product_last
);

	logic number_format_q;

	// Stage 1: decoded operands.
	logic v_s1, fmt_s1, last_s1;
	fem_pkg::unpacked_t op_s1;
	// Stage 2: raw significand product and exponent sum.
	logic v_s2, fmt_s2, last_s2, sign_s2;
	fem_pkg::kind_t kind_s2;
	logic [47:0] prod_s2;
	logic signed [9:0] esum_s2;
	// Stage 3: aligned product with rounding bits.
	logic v_s3, fmt_s3, last_s3, sign_s3;
	fem_pkg::kind_t kind_s3;
	fem_pkg::aligned_t al_s3;
	// Stage 4: output register.
	logic v_s4, fmt_s4, last_s4;
	logic [31:0] res_s4;

	logic rdy1, rdy2, rdy3, rdy4;
	fem_pkg::unpacked_t op_d;
	fem_pkg::aligned_t al_d;
	logic [31:0] res_d;

	// Each stage takes a new item when it is empty or its current item moves on.
	assign rdy4 = !v_s4 || m_axis_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_format_q <= 1'b0;
		end else if (cfg_we) begin
			number_format_q <= cfg_wdata;
		end
	end

	fem_unpack u_unpack (
		.fmt(number_format_q),
		.factor_a(s_axis_tdata[31:0]),
		.factor_b(s_axis_tdata[63:32]),
		.op(op_d)
	);

	fem_align u_align (
		.fmt(fmt_s2),
		.prod(prod_s2),
		.esum(esum_s2),
		.al(al_d)
	);

	fem_round u_round (
		.fmt(fmt_s3),
		.sign(sign_s3),
		.kind(kind_s3),
		.al(al_s3),
		.result(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1 <= op_d;
			fmt_s1 <= number_format_q;
			last_s1 <= s_axis_tlast;
		end
		if (rdy2) begin
			prod_s2 <= op_s1.ma * op_s1.mb;
			esum_s2 <= op_s1.ea + op_s1.eb - (fmt_s1 ? fem_pkg::BIAS16 : fem_pkg::BIAS32);
			kind_s2 <= op_s1.kind;
			sign_s2 <= op_s1.sign;
			fmt_s2 <= fmt_s1;
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			al_s3 <= al_d;
			kind_s3 <= kind_s2;
			sign_s3 <= sign_s2;
			fmt_s3 <= fmt_s2;
			last_s3 <= last_s2;
		end
		if (rdy4) begin
			res_s4 <= res_d;
			fmt_s4 <= fmt_s3;
			last_s4 <= last_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata = res_s4;
	assign m_axis_tlast = last_s4;

	// The input side only stalls when every stage holds an item.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled with an empty stage");

	// A blocked middle stage keeps its item.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy2) |=> v_s2)
		else $error("stage two lost an item while stalled");

	// Binary16 results are zero-extended.
	a_f16_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && fmt_s4) |-> (m_axis_tdata[31:16] == 16'd0))
		else $error("binary16 result has nonzero upper half");

endmodule
